### rtl/core/dql_pkg.sv
// ----------------------------------------------------------------------------
// dql_pkg
// Shared types, widths and helper functions of the dq current limiter.
// ----------------------------------------------------------------------------
package dql_pkg;

	// Current width and derived widths.
	localparam int CUR_W  = 16;
	localparam int LIM_W  = CUR_W - 1;
	localparam int SQ_W   = 2 * CUR_W;
	localparam int RT_W   = CUR_W;
	localparam int REM_W  = CUR_W + 3;
	localparam int NUM_W  = 2 * CUR_W - 1;
	localparam int PC_W   = 3;
	localparam int ADDR_W = 3;
	localparam int NPH    = 4;
	localparam int SYM_PH = 3;
	localparam int NLANE  = 2 * NPH;

	// Register reset values.
	localparam logic             SYM_RST  = 1'b1;
	localparam logic [PC_W-1:0]  PC_RST   = 3'd3;
	localparam logic [LIM_W-1:0] VMAX_RST = LIM_W'(4096);
	localparam logic [LIM_W-1:0] DPOS_RST = LIM_W'(4096);
	localparam logic [CUR_W-1:0] DNEG_RST = CUR_W'(-4096);
	localparam logic [LIM_W-1:0] QMAX_RST = LIM_W'(4096);
	localparam logic [SQ_W-1:0]  VSQ_RST  = SQ_W'(4096 * 4096);

	// Configuration register indexes.
	typedef enum logic [ADDR_W-1:0] {
		REG_SYM   = 3'd0,
		REG_PCNT  = 3'd1,
		REG_VMAX  = 3'd2,
		REG_DPOS  = 3'd3,
		REG_DNEG  = 3'd4,
		REG_QMAX  = 3'd5
	} cfg_reg_t;

	typedef struct packed {
		logic signed [CUR_W-1:0] d_phase_a;
		logic signed [CUR_W-1:0] q_phase_a;
		logic signed [CUR_W-1:0] d_phase_b;
		logic signed [CUR_W-1:0] q_phase_b;
		logic signed [CUR_W-1:0] d_phase_c;
		logic signed [CUR_W-1:0] q_phase_c;
		logic signed [CUR_W-1:0] d_neutral;
		logic signed [CUR_W-1:0] q_neutral;
	} dql_in_t;

	typedef struct packed {
		logic signed [CUR_W-1:0] d_out_a;
		logic signed [CUR_W-1:0] q_out_a;
		logic signed [CUR_W-1:0] d_out_b;
		logic signed [CUR_W-1:0] q_out_b;
		logic signed [CUR_W-1:0] d_out_c;
		logic signed [CUR_W-1:0] q_out_c;
		logic signed [CUR_W-1:0] d_out_neutral;
		logic signed [CUR_W-1:0] q_out_neutral;
		logic [NPH-1:0]          limited_mask;
	} dql_out_t;

	// Item state that travels down the pipeline next to the arithmetic units.
	typedef struct packed {
		logic [NPH-1:0][CUR_W-1:0] d;
		logic [NPH-1:0][CUR_W-1:0] q;
		logic [NPH-1:0]            act_a;
		logic [NPH-1:0]            act_b;
		logic [NPH-1:0]            over;
		logic [NPH-1:0]            hit;
		logic                      zero_n;
	} dql_carry_t;

	typedef logic [NPH-1:0][SQ_W-1:0]    rad_vec_t;
	typedef logic [NPH-1:0][REM_W-1:0]   rem_vec_t;
	typedef logic [NPH-1:0][RT_W-1:0]    root_vec_t;
	typedef logic [NLANE-1:0][NUM_W-1:0] num_vec_t;
	typedef logic [NLANE-1:0][RT_W-1:0]  den_vec_t;
	typedef logic [NLANE-1:0][CUR_W-1:0] quo_vec_t;

	// Magnitude of a two's complement current, as an unsigned value.
	function automatic logic [CUR_W-1:0] cur_abs(input logic [CUR_W-1:0] x);
		return x[CUR_W-1] ? (~x + 1'b1) : x;
	endfunction

	// Square of a current.
	function automatic logic [SQ_W-1:0] cur_sq(input logic [CUR_W-1:0] x);
		logic [CUR_W-1:0] a;
		a = cur_abs(x);
		return SQ_W'(a) * SQ_W'(a);
	endfunction

	// Magnitude of a current times the vector limit.
	function automatic logic [NUM_W-1:0] cur_num(input logic [CUR_W-1:0] x,
		input logic [LIM_W-1:0] vmax);
		return NUM_W'(cur_abs(x)) * NUM_W'(vmax);
	endfunction

	// Puts the sign of the original value back on a scaled magnitude.
	function automatic logic [CUR_W-1:0] apply_sign(input logic [CUR_W-1:0] x,
		input logic [CUR_W-1:0] mag);
		return x[CUR_W-1] ? (~mag + 1'b1) : mag;
	endfunction

endpackage

### rtl/core/dql_isqrt.sv
// ----------------------------------------------------------------------------
// dql_isqrt
// Pipelined integer square root, one result bit per stage, on all phase lanes.
// ----------------------------------------------------------------------------
module dql_isqrt (
	input  logic                 clk,
	input  logic                 arst_n,
	input  logic                 en,
	input  logic                 in_valid,
	input  dql_pkg::dql_carry_t  in_carry,
	input  dql_pkg::rad_vec_t    in_rad,
	output logic                 out_valid,
	output dql_pkg::dql_carry_t  out_carry,
	output dql_pkg::root_vec_t   out_root
);

	logic                      valid_s [dql_pkg::CUR_W];
	dql_pkg::dql_carry_t       carry_s [dql_pkg::CUR_W];
	dql_pkg::rad_vec_t         rad_s   [dql_pkg::CUR_W];
	dql_pkg::rem_vec_t         rem_s   [dql_pkg::CUR_W];
	dql_pkg::root_vec_t        root_s  [dql_pkg::CUR_W];

	genvar k;
	generate
		for (k = 0; k < dql_pkg::CUR_W; k++) begin : g_step
			logic                vld_p;
			dql_pkg::dql_carry_t carry_p;
			dql_pkg::rad_vec_t   rad_p;
			dql_pkg::rem_vec_t   rem_p;
			dql_pkg::root_vec_t  root_p;
			dql_pkg::rad_vec_t   rad_n;
			dql_pkg::rem_vec_t   rem_n;
			dql_pkg::root_vec_t  root_n;

			// The first stage starts from an empty remainder and root.
			if (k == 0) begin : g_first
				assign vld_p   = in_valid;
				assign carry_p = in_carry;
				assign rad_p   = in_rad;
				assign rem_p   = '0;
				assign root_p  = '0;
			end else begin : g_next
				assign vld_p   = valid_s[k-1];
				assign carry_p = carry_s[k-1];
				assign rad_p   = rad_s[k-1];
				assign rem_p   = rem_s[k-1];
				assign root_p  = root_s[k-1];
			end

			// Bring in the next two radicand bits and try the next root bit.
			always_comb begin
				logic [dql_pkg::REM_W-1:0] shifted;
				logic [dql_pkg::REM_W-1:0] trial;
				for (int l = 0; l < dql_pkg::NPH; l++) begin
					shifted  = {rem_p[l][dql_pkg::REM_W-3:0],
						rad_p[l][dql_pkg::SQ_W-1 -: 2]};
					trial    = {1'b0, root_p[l], 2'b01};
					rad_n[l] = {rad_p[l][dql_pkg::SQ_W-3:0], 2'b00};
					if (shifted >= trial) begin
						rem_n[l]  = shifted - trial;
						root_n[l] = {root_p[l][dql_pkg::RT_W-2:0], 1'b1};
					end else begin
						rem_n[l]  = shifted;
						root_n[l] = {root_p[l][dql_pkg::RT_W-2:0], 1'b0};
					end
				end
			end

			always_ff @(posedge clk or negedge arst_n) begin
				if (!arst_n) begin
					valid_s[k] <= 1'b0;
				end else if (en) begin
					valid_s[k] <= vld_p;
				end
			end

			always_ff @(posedge clk) begin
				if (en) begin
					carry_s[k] <= carry_p;
					rad_s[k]   <= rad_n;
					rem_s[k]   <= rem_n;
					root_s[k]  <= root_n;
				end
			end
		end
	endgenerate

	assign out_valid = valid_s[dql_pkg::CUR_W-1];
	assign out_carry = carry_s[dql_pkg::CUR_W-1];
	assign out_root  = root_s[dql_pkg::CUR_W-1];

endmodule

### rtl/core/dql_div.sv
// ----------------------------------------------------------------------------
// dql_div
// Pipelined restoring divider, one quotient bit per stage, on all d/q lanes.
// ----------------------------------------------------------------------------
module dql_div (
	input  logic                 clk,
	input  logic                 arst_n,
	input  logic                 en,
	input  logic                 in_valid,
	input  dql_pkg::dql_carry_t  in_carry,
	input  dql_pkg::num_vec_t    in_num,
	input  dql_pkg::den_vec_t    in_den,
	output logic                 out_valid,
	output dql_pkg::dql_carry_t  out_carry,
	output dql_pkg::quo_vec_t    out_quo
);

	logic                      valid_s [dql_pkg::CUR_W];
	dql_pkg::dql_carry_t       carry_s [dql_pkg::CUR_W];
	dql_pkg::num_vec_t         num_s   [dql_pkg::CUR_W];
	dql_pkg::den_vec_t         den_s   [dql_pkg::CUR_W];
	dql_pkg::quo_vec_t         rem_s   [dql_pkg::CUR_W];
	dql_pkg::quo_vec_t         quo_s   [dql_pkg::CUR_W];

	genvar k;
	generate
		for (k = 0; k < dql_pkg::CUR_W; k++) begin : g_step
			logic                vld_p;
			dql_pkg::dql_carry_t carry_p;
			dql_pkg::num_vec_t   num_p;
			dql_pkg::den_vec_t   den_p;
			dql_pkg::quo_vec_t   rem_p;
			dql_pkg::quo_vec_t   quo_p;
			dql_pkg::quo_vec_t   rem_n;
			dql_pkg::quo_vec_t   quo_n;

			// The quotient fits the current width, so the upper numerator
			// bits form the starting remainder.
			if (k == 0) begin : g_first
				assign vld_p   = in_valid;
				assign carry_p = in_carry;
				assign num_p   = in_num;
				assign den_p   = in_den;
				assign quo_p   = '0;
				always_comb begin
					for (int l = 0; l < dql_pkg::NLANE; l++) begin
						rem_p[l] = {1'b0, in_num[l][dql_pkg::NUM_W-1:dql_pkg::CUR_W]};
					end
				end
			end else begin : g_next
				assign vld_p   = valid_s[k-1];
				assign carry_p = carry_s[k-1];
				assign num_p   = num_s[k-1];
				assign den_p   = den_s[k-1];
				assign rem_p   = rem_s[k-1];
				assign quo_p   = quo_s[k-1];
			end

			// Shift in one numerator bit and subtract the divisor if it fits.
			always_comb begin
				logic [dql_pkg::CUR_W:0] shifted;
				logic [dql_pkg::CUR_W:0] diff;
				for (int l = 0; l < dql_pkg::NLANE; l++) begin
					shifted = {rem_p[l], num_p[l][dql_pkg::CUR_W-1-k]};
					diff    = shifted - {1'b0, den_p[l]};
					if (shifted >= {1'b0, den_p[l]}) begin
						rem_n[l] = diff[dql_pkg::CUR_W-1:0];
						quo_n[l] = {quo_p[l][dql_pkg::CUR_W-2:0], 1'b1};
					end else begin
						rem_n[l] = shifted[dql_pkg::CUR_W-1:0];
						quo_n[l] = {quo_p[l][dql_pkg::CUR_W-2:0], 1'b0};
					end
				end
			end

			always_ff @(posedge clk or negedge arst_n) begin
				if (!arst_n) begin
					valid_s[k] <= 1'b0;
				end else if (en) begin
					valid_s[k] <= vld_p;
				end
			end

			always_ff @(posedge clk) begin
				if (en) begin
					carry_s[k] <= carry_p;
					num_s[k]   <= num_p;
					den_s[k]   <= den_p;
					rem_s[k]   <= rem_n;
					quo_s[k]   <= quo_n;
				end
			end
		end
	endgenerate

	assign out_valid = valid_s[dql_pkg::CUR_W-1];
	assign out_carry = carry_s[dql_pkg::CUR_W-1];
	assign out_quo   = quo_s[dql_pkg::CUR_W-1];

endmodule

### rtl/core/dq_current_two_stage_limiter.sv
// ----------------------------------------------------------------------------
// dq_current_two_stage_limiter
// Two-stage dq current vector limiter for phases A, B, C and neutral.
// ----------------------------------------------------------------------------
// The limiter accepts one set of phase current references per clock cycle while
// the output is not held off and returns the limited set through two square
// root pipelines and two divider pipelines of one bit per stage each, plus ten
// stages of squaring, clamping and scaling. The whole pipeline moves as one:
// when the output transfer is held off, every stage holds, and in_ready drops.
// Configuration writes must only be made while no item is in flight.
module dq_current_two_stage_limiter (
	input  logic                             clk,
	input  logic                             arst_n,
	input  logic                             cfg_we,
	input  logic [dql_pkg::ADDR_W-1:0]       cfg_addr,
	input  logic [dql_pkg::CUR_W-1:0]        cfg_data,
	input  logic                             in_valid,
	output logic                             in_ready,
	input  dql_pkg::dql_in_t                 in_item,
	output logic                             out_valid,
	input  logic                             out_ready,
	output dql_pkg::dql_out_t                out_item
);

	// Configuration registers.
	logic                           sym_q;
	logic [dql_pkg::PC_W-1:0]       pcnt_q;
	logic [dql_pkg::LIM_W-1:0]      vmax_q;
	logic [dql_pkg::LIM_W-1:0]      dpos_q;
	logic signed [dql_pkg::CUR_W-1:0] dneg_q;
	logic [dql_pkg::LIM_W-1:0]      qmax_q;
	logic [dql_pkg::SQ_W-1:0]       vmax_sq_q;

	logic en;

	// Pipeline registers.
	logic                valid_s1, valid_s2, valid_s3, valid_s4, valid_s5;
	logic                valid_s6, valid_s7, valid_s8, valid_s9, valid_s10;
	dql_pkg::dql_carry_t carry_s1, carry_s2, carry_s3, carry_s4, carry_s5;
	dql_pkg::dql_carry_t carry_s6, carry_s7, carry_s8, carry_s9;
	logic [dql_pkg::SQ_W-1:0] sqd_s2, sqq_s2, sum_s3;
	dql_pkg::num_vec_t   num_s4, num_s9;
	dql_pkg::den_vec_t   den_s4, den_s9;
	dql_pkg::rad_vec_t   sqd_s7, sqq_s7, rad_s8;
	dql_pkg::dql_out_t   out_s10;
	logic [dql_pkg::NPH-1:0] actb_s10, over_s10;
	logic                zero_s10;

	// Unit outputs.
	logic                sqa_valid, dva_valid, sqb_valid, dvb_valid;
	dql_pkg::dql_carry_t sqa_carry, dva_carry, sqb_carry, dvb_carry;
	dql_pkg::root_vec_t  sqa_root, sqb_root;
	dql_pkg::quo_vec_t   dva_quo, dvb_quo;

	// Combinational stage inputs.
	dql_pkg::dql_carry_t entry_carry, carry_s3_n, carry_s5_n, carry_s6_n, carry_s8_n;
	dql_pkg::rad_vec_t   rad_a;
	dql_pkg::rad_vec_t   sqd_n, sqq_n, rad_b;
	dql_pkg::num_vec_t   num_a_n, num_b_n;
	dql_pkg::den_vec_t   den_a_n, den_b_n;
	dql_pkg::dql_out_t   out_n;

	// The pipeline advances whenever the output register is free or drains.
	assign en        = !valid_s10 || out_ready;
	assign in_ready  = en;
	assign out_valid = valid_s10;
	assign out_item  = out_s10;

	// Configuration writes; the squared limit follows in the next cycle.
	always_ff @(posedge clk or negedge arst_n) begin
		if (!arst_n) begin
			sym_q     <= dql_pkg::SYM_RST;
			pcnt_q    <= dql_pkg::PC_RST;
			vmax_q    <= dql_pkg::VMAX_RST;
			dpos_q    <= dql_pkg::DPOS_RST;
			dneg_q    <= dql_pkg::DNEG_RST;
			qmax_q    <= dql_pkg::QMAX_RST;
			vmax_sq_q <= dql_pkg::VSQ_RST;
		end else begin
			vmax_sq_q <= dql_pkg::SQ_W'(vmax_q) * dql_pkg::SQ_W'(vmax_q);
			if (cfg_we) begin
				unique case (dql_pkg::cfg_reg_t'(cfg_addr))
					dql_pkg::REG_SYM:  sym_q  <= cfg_data[0];
					dql_pkg::REG_PCNT: pcnt_q <= cfg_data[dql_pkg::PC_W-1:0];
					dql_pkg::REG_VMAX: vmax_q <= cfg_data[dql_pkg::LIM_W-1:0];
					dql_pkg::REG_DPOS: dpos_q <= cfg_data[dql_pkg::LIM_W-1:0];
					dql_pkg::REG_DNEG: dneg_q <= cfg_data;
					dql_pkg::REG_QMAX: qmax_q <= cfg_data[dql_pkg::LIM_W-1:0];
					default: ;
				endcase
			end
		end
	end

	// Entry: decode which phases each limiting stage acts on.
	always_comb begin
		logic [dql_pkg::PC_W-1:0] n_act;
		logic [dql_pkg::PC_W-1:0] n_sym;
		n_act = (pcnt_q > dql_pkg::PC_W'(dql_pkg::NPH)) ?
			dql_pkg::PC_W'(dql_pkg::NPH) : pcnt_q;
		n_sym = (n_act > dql_pkg::PC_W'(dql_pkg::SYM_PH)) ?
			dql_pkg::PC_W'(dql_pkg::SYM_PH) : n_act;
		entry_carry      = '0;
		entry_carry.d[0] = in_item.d_phase_a;
		entry_carry.q[0] = in_item.q_phase_a;
		entry_carry.d[1] = in_item.d_phase_b;
		entry_carry.q[1] = in_item.q_phase_b;
		entry_carry.d[2] = in_item.d_phase_c;
		entry_carry.q[2] = in_item.q_phase_c;
		entry_carry.d[3] = in_item.d_neutral;
		entry_carry.q[3] = in_item.q_neutral;
		for (int i = 0; i < dql_pkg::NPH; i++) begin
			entry_carry.act_a[i] = sym_q && (dql_pkg::PC_W'(i) < n_sym);
			entry_carry.act_b[i] = sym_q ? (dql_pkg::PC_W'(i) < n_sym) :
				(dql_pkg::PC_W'(i) < n_act);
		end
		entry_carry.zero_n = sym_q && (n_act > dql_pkg::PC_W'(dql_pkg::SYM_PH));
	end

	// Stage A front: phase A squares, then its sum and limit test.
	always_comb begin
		carry_s3_n         = carry_s2;
		carry_s3_n.over    = '0;
		carry_s3_n.over[0] = (sqd_s2 + sqq_s2) > vmax_sq_q;
		rad_a              = '0;
		rad_a[0]           = sum_s3;
	end

	// Stage A scale: every lane is divided by phase A's magnitude.
	always_comb begin
		for (int l = 0; l < dql_pkg::NLANE; l++) begin
			num_a_n[l] = dql_pkg::cur_num((l % 2 == 0) ? sqa_carry.d[l/2] :
				sqa_carry.q[l/2], vmax_q);
			den_a_n[l] = sqa_root[0];
		end
	end

	// Stage A apply: only phases of the symmetric set take the scaled values.
	always_comb begin
		carry_s5_n = dva_carry;
		for (int i = 0; i < dql_pkg::NPH; i++) begin
			if (dva_carry.act_a[i] && dva_carry.over[0]) begin
				carry_s5_n.d[i] = dql_pkg::apply_sign(dva_carry.d[i], dva_quo[2*i]);
				carry_s5_n.q[i] = dql_pkg::apply_sign(dva_carry.q[i], dva_quo[2*i+1]);
			end
		end
		carry_s5_n.over = '0;
	end

	// Stage B clamp: d to its two bounds, q to plus or minus its bound.
	always_comb begin
		logic signed [dql_pkg::CUR_W-1:0] dv;
		logic signed [dql_pkg::CUR_W-1:0] qv;
		logic signed [dql_pkg::CUR_W-1:0] dpos_s;
		logic signed [dql_pkg::CUR_W-1:0] qmax_s;
		dpos_s     = $signed({1'b0, dpos_q});
		qmax_s     = $signed({1'b0, qmax_q});
		carry_s6_n = carry_s5;
		for (int i = 0; i < dql_pkg::NPH; i++) begin
			dv = $signed(carry_s5.d[i]);
			qv = $signed(carry_s5.q[i]);
			carry_s6_n.hit[i] = 1'b0;
			if (carry_s5.act_b[i]) begin
				priority if (dv > dpos_s) begin
					carry_s6_n.d[i]   = dpos_s;
					carry_s6_n.hit[i] = 1'b1;
				end else if (dv < dneg_q) begin
					carry_s6_n.d[i]   = dneg_q;
					carry_s6_n.hit[i] = 1'b1;
				end else begin
					carry_s6_n.d[i]   = dv;
				end
				priority if (qv > qmax_s) begin
					carry_s6_n.q[i]   = qmax_s;
					carry_s6_n.hit[i] = 1'b1;
				end else if (qv < -qmax_s) begin
					carry_s6_n.q[i]   = -qmax_s;
					carry_s6_n.hit[i] = 1'b1;
				end else begin
					carry_s6_n.q[i]   = qv;
				end
			end
		end
	end

	// Stage B squares and limit test per phase.
	always_comb begin
		carry_s8_n = carry_s7;
		for (int i = 0; i < dql_pkg::NPH; i++) begin
			sqd_n[i] = dql_pkg::cur_sq(carry_s6.d[i]);
			sqq_n[i] = dql_pkg::cur_sq(carry_s6.q[i]);
			rad_b[i] = sqd_s7[i] + sqq_s7[i];
			carry_s8_n.over[i] = carry_s7.act_b[i] && (rad_b[i] > vmax_sq_q);
		end
	end

	// Stage B scale: each phase is divided by its own magnitude.
	always_comb begin
		for (int l = 0; l < dql_pkg::NLANE; l++) begin
			num_b_n[l] = dql_pkg::cur_num((l % 2 == 0) ? sqb_carry.d[l/2] :
				sqb_carry.q[l/2], vmax_q);
			den_b_n[l] = sqb_root[l/2];
		end
	end

	// Result: apply the scaling, zero the neutral and build the mask.
	always_comb begin
		logic [dql_pkg::NPH-1:0][dql_pkg::CUR_W-1:0] d_r;
		logic [dql_pkg::NPH-1:0][dql_pkg::CUR_W-1:0] q_r;
		for (int i = 0; i < dql_pkg::NPH; i++) begin
			d_r[i] = dvb_carry.over[i] ?
				dql_pkg::apply_sign(dvb_carry.d[i], dvb_quo[2*i]) : dvb_carry.d[i];
			q_r[i] = dvb_carry.over[i] ?
				dql_pkg::apply_sign(dvb_carry.q[i], dvb_quo[2*i+1]) : dvb_carry.q[i];
		end
		if (dvb_carry.zero_n) begin
			d_r[dql_pkg::NPH-1] = '0;
			q_r[dql_pkg::NPH-1] = '0;
		end
		out_n.d_out_a       = d_r[0];
		out_n.q_out_a       = q_r[0];
		out_n.d_out_b       = d_r[1];
		out_n.q_out_b       = q_r[1];
		out_n.d_out_c       = d_r[2];
		out_n.q_out_c       = q_r[2];
		out_n.d_out_neutral = d_r[3];
		out_n.q_out_neutral = q_r[3];
		out_n.limited_mask  = dvb_carry.act_b & (dvb_carry.hit | dvb_carry.over);
	end

	// Valid bits of the pipeline stages held in this module.
	always_ff @(posedge clk or negedge arst_n) begin
		if (!arst_n) begin
			valid_s1  <= 1'b0;
			valid_s2  <= 1'b0;
			valid_s3  <= 1'b0;
			valid_s4  <= 1'b0;
			valid_s5  <= 1'b0;
			valid_s6  <= 1'b0;
			valid_s7  <= 1'b0;
			valid_s8  <= 1'b0;
			valid_s9  <= 1'b0;
			valid_s10 <= 1'b0;
		end else if (en) begin
			valid_s1  <= in_valid;
			valid_s2  <= valid_s1;
			valid_s3  <= valid_s2;
			valid_s4  <= sqa_valid;
			valid_s5  <= dva_valid;
			valid_s6  <= valid_s5;
			valid_s7  <= valid_s6;
			valid_s8  <= valid_s7;
			valid_s9  <= sqb_valid;
			valid_s10 <= dvb_valid;
		end
	end

	// Payload of the pipeline stages held in this module.
	always_ff @(posedge clk) begin
		if (en) begin
			carry_s1  <= entry_carry;
			carry_s2  <= carry_s1;
			sqd_s2    <= dql_pkg::cur_sq(carry_s1.d[0]);
			sqq_s2    <= dql_pkg::cur_sq(carry_s1.q[0]);
			carry_s3  <= carry_s3_n;
			sum_s3    <= sqd_s2 + sqq_s2;
			carry_s4  <= sqa_carry;
			num_s4    <= num_a_n;
			den_s4    <= den_a_n;
			carry_s5  <= carry_s5_n;
			carry_s6  <= carry_s6_n;
			carry_s7  <= carry_s6;
			sqd_s7    <= sqd_n;
			sqq_s7    <= sqq_n;
			carry_s8  <= carry_s8_n;
			rad_s8    <= rad_b;
			carry_s9  <= sqb_carry;
			num_s9    <= num_b_n;
			den_s9    <= den_b_n;
			out_s10   <= out_n;
			actb_s10  <= dvb_carry.act_b;
			over_s10  <= dvb_carry.over;
			zero_s10  <= dvb_carry.zero_n;
		end
	end

	dql_isqrt u_sqrt_a (
		.clk       (clk),
		.arst_n    (arst_n),
		.en        (en),
		.in_valid  (valid_s3),
		.in_carry  (carry_s3),
		.in_rad    (rad_a),
		.out_valid (sqa_valid),
		.out_carry (sqa_carry),
		.out_root  (sqa_root)
	);

	dql_div u_div_a (
		.clk       (clk),
		.arst_n    (arst_n),
		.en        (en),
		.in_valid  (valid_s4),
		.in_carry  (carry_s4),
		.in_num    (num_s4),
		.in_den    (den_s4),
		.out_valid (dva_valid),
		.out_carry (dva_carry),
		.out_quo   (dva_quo)
	);

	dql_isqrt u_sqrt_b (
		.clk       (clk),
		.arst_n    (arst_n),
		.en        (en),
		.in_valid  (valid_s8),
		.in_carry  (carry_s8),
		.in_rad    (rad_s8),
		.out_valid (sqb_valid),
		.out_carry (sqb_carry),
		.out_root  (sqb_root)
	);

	dql_div u_div_b (
		.clk       (clk),
		.arst_n    (arst_n),
		.en        (en),
		.in_valid  (valid_s9),
		.in_carry  (carry_s9),
		.in_num    (num_s9),
		.in_den    (den_s9),
		.out_valid (dvb_valid),
		.out_carry (dvb_carry),
		.out_quo   (dvb_quo)
	);

	// A phase outside the limited set never reports limiting.
	a_mask_active: assert property (@(posedge clk) disable iff (!arst_n)
		valid_s10 |-> ((out_s10.limited_mask & ~actb_s10) == '0))
		else $error("limited_mask flags a phase that was not limited");

	// A zeroed neutral leaves both components at zero and no mask bit.
	a_neutral_zero: assert property (@(posedge clk) disable iff (!arst_n)
		valid_s10 && zero_s10 |-> (out_s10.d_out_neutral == '0) &&
		(out_s10.q_out_neutral == '0) && !out_s10.limited_mask[dql_pkg::NPH-1])
		else $error("neutral not zeroed in symmetric mode");

	// After vector scaling phase A's d component lies within the limit.
	a_scaled_bound: assert property (@(posedge clk) disable iff (!arst_n)
		valid_s10 && over_s10[0] |->
		($signed(out_s10.d_out_a) <= $signed({1'b0, vmax_q})) &&
		($signed(out_s10.d_out_a) >= -$signed({1'b0, vmax_q})))
		else $error("scaled phase A d exceeds the vector limit");

endmodule

### verif/dql_checker.sv
`timescale 1ns / 100ps
// ----------------------------------------------------------------------------
// dql_checker
// Watches the configuration port and both channels of the dq current limiter,
// computes the expected limited currents for every input transfer and compares
// each output transfer with the oldest expected result.
// ----------------------------------------------------------------------------
module dql_checker (
	input  logic                       clk,
	input  logic                       arst_n,
	input  logic                       cfg_we,
	input  logic [dql_pkg::ADDR_W-1:0] cfg_addr,
	input  logic [dql_pkg::CUR_W-1:0]  cfg_data,
	input  logic                       in_valid,
	input  logic                       in_ready,
	input  dql_pkg::dql_in_t           in_item,
	input  logic                       out_valid,
	input  logic                       out_ready,
	input  dql_pkg::dql_out_t          out_item,
	output int                         fail_count,
	output int                         pending_count,
	output int                         result_count,
	output int                         limited_count
);
	import dql_pkg::*;

	// Shadow copy of the configuration registers.
	logic            sym_mode;
	logic [PC_W-1:0] phase_cnt;
	longint          vmax, dpos, dneg, qmax;

	dql_out_t limited_fifo[$];

	// Integer square root, rounded down.
	function automatic longint floor_sqrt(longint x);
		longint r;
		r = 0;
		for (longint b = 64'd1 << 62; b != 0; b = b >> 2) begin
			if (x >= r + b) begin
				x = x - (r + b);
				r = (r >> 1) + b;
			end else begin
				r = r >> 1;
			end
		end
		return r;
	endfunction

	// Magnitude of the vector when it exceeds the limit, else zero.
	function automatic longint excess_mag(longint d, longint q);
		longint s;
		s = d * d + q * q;
		return (s > vmax * vmax) ? floor_sqrt(s) : 0;
	endfunction

	// Scales toward zero by vmax / m.
	function automatic longint shrink(longint x, longint m);
		longint a;
		a = ((x < 0 ? -x : x) * vmax) / m;
		return x < 0 ? -a : a;
	endfunction

	// Clamps then vector-limits one phase; returns whether anything changed.
	function automatic bit clamp_phase(inout longint d, inout longint q);
		bit hit;
		longint m;
		hit = 0;
		if (d > dpos) begin
			d = dpos;
			hit = 1;
		end else if (d < dneg) begin
			d = dneg;
			hit = 1;
		end
		if (q > qmax) begin
			q = qmax;
			hit = 1;
		end else if (q < -qmax) begin
			q = -qmax;
			hit = 1;
		end
		m = excess_mag(d, q);
		if (m != 0) begin
			d = shrink(d, m);
			q = shrink(q, m);
			hit = 1;
		end
		return hit;
	endfunction

	function automatic dql_out_t limit_currents(dql_in_t x);
		longint d[NPH], q[NPH];
		int n, ns;
		logic [NPH-1:0] mask;
		longint m;
		dql_out_t r;
		d[0] = x.d_phase_a; q[0] = x.q_phase_a;
		d[1] = x.d_phase_b; q[1] = x.q_phase_b;
		d[2] = x.d_phase_c; q[2] = x.q_phase_c;
		d[3] = x.d_neutral; q[3] = x.q_neutral;
		n = (phase_cnt > NPH) ? NPH : int'(phase_cnt);
		mask = '0;
		if (sym_mode) begin
			ns = (n < SYM_PH) ? n : SYM_PH;
			m = excess_mag(d[0], q[0]);
			if (m != 0) begin
				for (int i = 0; i < ns; i++) begin
					d[i] = shrink(d[i], m);
					q[i] = shrink(q[i], m);
				end
			end
			for (int i = 0; i < ns; i++)
				if (clamp_phase(d[i], q[i]))
					mask[i] = 1'b1;
			if (n > SYM_PH) begin
				d[SYM_PH] = 0;
				q[SYM_PH] = 0;
			end
		end else begin
			for (int i = 0; i < n; i++)
				if (clamp_phase(d[i], q[i]))
					mask[i] = 1'b1;
		end
		r.d_out_a = CUR_W'(d[0]); r.q_out_a = CUR_W'(q[0]);
		r.d_out_b = CUR_W'(d[1]); r.q_out_b = CUR_W'(q[1]);
		r.d_out_c = CUR_W'(d[2]); r.q_out_c = CUR_W'(q[2]);
		r.d_out_neutral = CUR_W'(d[3]); r.q_out_neutral = CUR_W'(q[3]);
		r.limited_mask = mask;
		return r;
	endfunction

	// Track configuration, predict on input transfers, compare on output transfers.
	always @(posedge clk or negedge arst_n) begin
		dql_out_t want;
		if (!arst_n) begin
			sym_mode <= SYM_RST;
			phase_cnt <= PC_RST;
			vmax = VMAX_RST;
			dpos = DPOS_RST;
			dneg = $signed(DNEG_RST);
			qmax = QMAX_RST;
			fail_count <= 0;
			result_count <= 0;
			limited_count <= 0;
			limited_fifo.delete();
			pending_count <= 0;
		end else begin
			if (cfg_we) begin
				case (cfg_reg_t'(cfg_addr))
					REG_SYM: sym_mode <= cfg_data[0];
					REG_PCNT: phase_cnt <= cfg_data[PC_W-1:0];
					REG_VMAX: vmax = cfg_data[LIM_W-1:0];
					REG_DPOS: dpos = cfg_data[LIM_W-1:0];
					REG_DNEG: dneg = $signed(cfg_data);
					REG_QMAX: qmax = cfg_data[LIM_W-1:0];
					default: ;
				endcase
			end
			if (in_valid && in_ready)
				limited_fifo.push_back(limit_currents(in_item));
			if (out_valid && out_ready) begin
				result_count <= result_count + 1;
				if (out_item.limited_mask != 0)
					limited_count <= limited_count + 1;
				if (limited_fifo.size() == 0) begin
					$display("%0t: unexpected result %h", $time, out_item);
					fail_count <= fail_count + 1;
				end else begin
					want = limited_fifo.pop_front();
					if (want !== out_item) begin
						$display("%0t: mismatch expected %h actual %h", $time, want, out_item);
						fail_count <= fail_count + 1;
					end
				end
			end
			pending_count <= limited_fifo.size();
		end
	end

endmodule

### verif/tb_top.sv
`timescale 1ns / 100ps
// ----------------------------------------------------------------------------
// tb_top
// Drives the dq current limiter with directed and random phase currents over
// several register settings, with random stalls on both channels.
// ----------------------------------------------------------------------------
module tb_top;
	import dql_pkg::*;

	localparam int LATENCY = 74;
	localparam int WATCHDOG = 20000;

	logic clk = 1'b0;
	logic arst_n = 1'b0;
	logic cfg_we = 1'b0;
	logic [ADDR_W-1:0] cfg_addr = '0;
	logic [CUR_W-1:0] cfg_data = '0;
	logic in_valid = 1'b0;
	logic in_ready;
	dql_in_t in_item = '0;
	logic out_valid;
	logic out_ready = 1'b0;
	dql_out_t out_item;
	int fail_count, pending_count, result_count, limited_count;
	int idle_cycles = 0;
	bit press_go = 0;
	bit hold_off = 0;

	always #5 clk = ~clk;

	dq_current_two_stage_limiter uut (.*);

	dql_checker chk (.*);

	// Random current with bias toward extremes and the limit region.
	function automatic logic [CUR_W-1:0] rand_current();
		case ($urandom_range(0, 5))
			0: return CUR_W'($urandom);
			1: return $urandom_range(0, 1) ? 16'h7fff : 16'h8000;
			2: return CUR_W'($urandom_range(0, 12000)) ^
				($urandom_range(0, 1) ? 16'hffff : 16'h0000);
			default: return CUR_W'(int'($urandom_range(0, 16000)) - 8000);
		endcase
	endfunction

	function automatic dql_in_t rand_item();
		dql_in_t x;
		x.d_phase_a = rand_current(); x.q_phase_a = rand_current();
		x.d_phase_b = rand_current(); x.q_phase_b = rand_current();
		x.d_phase_c = rand_current(); x.q_phase_c = rand_current();
		x.d_neutral = rand_current(); x.q_neutral = rand_current();
		return x;
	endfunction

	function automatic int gap_len();
		return ($urandom_range(0, 19) == 0) ? $urandom_range(5, 30) : $urandom_range(0, 2);
	endfunction

	task automatic write_reg(cfg_reg_t idx, logic [CUR_W-1:0] val);
		cfg_we <= 1'b1;
		cfg_addr <= idx;
		cfg_data <= val;
		@(negedge clk);
		cfg_we <= 1'b0;
	endtask

	// Offers one item and waits for its transfer.
	task automatic send_item(dql_in_t x);
		in_valid <= 1'b1;
		in_item <= x;
		do @(posedge clk); while (!in_ready);
		@(negedge clk);
		in_valid <= 1'b0;
	endtask

	task automatic send_random(int count, bit gaps);
		dql_in_t x;
		for (int i = 0; i < count; i++) begin
			x = rand_item();
			in_valid <= 1'b1;
			in_item <= x;
			do @(posedge clk); while (!in_ready);
			@(negedge clk);
			if (gaps) begin
				int g;
				g = gap_len();
				if (g > 0) begin
					in_valid <= 1'b0;
					repeat (g) @(negedge clk);
				end
			end
		end
		in_valid <= 1'b0;
	endtask

	// Waits until all results are back plus the pipeline depth.
	task automatic drain();
		while (pending_count != 0) @(negedge clk);
		repeat (LATENCY + 4) @(negedge clk);
	endtask

	task automatic apply_setting(bit sym, int pc, int vm, int dp, int dn, int qm);
		write_reg(REG_SYM, CUR_W'(sym));
		write_reg(REG_PCNT, CUR_W'(pc));
		write_reg(REG_VMAX, CUR_W'(vm));
		write_reg(REG_DPOS, CUR_W'(dp));
		write_reg(REG_DNEG, CUR_W'(dn));
		write_reg(REG_QMAX, CUR_W'(qm));
	endtask

	// Receiver side: random stalls, and one long hold-off on request.
	always @(negedge clk) begin
		if (hold_off)
			out_ready <= 1'b0;
		else if ($urandom_range(0, 3) == 0)
			out_ready <= ($urandom_range(0, 9) == 0) ? 1'b0 : ~out_ready;
		else
			out_ready <= ($urandom_range(0, 9) != 0);
	end

	// Long hold-off while a back-to-back burst is being offered.
	initial begin
		wait (press_go);
		repeat (10) @(negedge clk);
		hold_off = 1;
		repeat (200) @(negedge clk);
		hold_off = 0;
	end

	// Watchdog on cycles with no transfer.
	always @(posedge clk) begin
		if ((in_valid && in_ready) || (out_valid && out_ready) || cfg_we)
			idle_cycles <= 0;
		else
			idle_cycles <= idle_cycles + 1;
		if (idle_cycles >= WATCHDOG) begin
			$display("FAILURE");
			$finish;
		end
	end

	initial begin
		dql_in_t x;
		repeat (2) @(negedge clk);
		arst_n <= 1'b1;
		@(negedge clk);

		// Directed items under reset settings and extreme settings.
		x = '{16'h7fff, 16'h7fff, 16'h8000, 16'h8000, 16'h7fff, 16'h8000,
			16'h8000, 16'h7fff};
		send_item(x);
		send_item('0);
		x = '{16'd3000, -16'sd3000, 16'd100, 16'd200, -16'sd5000, 16'd0,
			16'd9000, -16'sd9000};
		send_item(x);
		send_item({8{16'hffff}});
		send_item({8{16'h5555}});
		send_item({8{16'haaaa}});
		send_random(4, 0);
		drain();
		apply_setting(1, 4, 5000, 3000, -2000, 2500);
		send_item(x);
		send_random(4, 0);
		drain();
		apply_setting(0, 0, 0, 0, 0, 0);
		send_item(x);
		send_random(2, 0);
		drain();
		write_reg(REG_PCNT, 3'd7);
		send_item(x);
		send_item({8{16'h8000}});
		drain();
		// Wide limits with a narrow positive d bound, then zero limits.
		apply_setting(0, 4, 32767, 100, -32768, 32767);
		send_item(x);
		send_random(2, 0);
		drain();
		apply_setting(1, 2, 0, 0, 16'h8000, 0);
		send_item(x);
		send_random(2, 0);
		drain();

		// Random phases over a sequence of settings.
		for (int p = 0; p < 16; p++) begin
			case (p % 4)
				0: apply_setting($urandom_range(0, 1), $urandom_range(0, 7),
					$urandom_range(0, 32767), $urandom_range(0, 32767),
					-int'($urandom_range(0, 32768)), $urandom_range(0, 32767));
				1: apply_setting(p[2], 4, 32767, 32767, -32768, 32767);
				2: apply_setting($urandom_range(0, 1), $urandom_range(1, 4),
					$urandom_range(2000, 9000), $urandom_range(1000, 9000),
					-int'($urandom_range(1000, 9000)), $urandom_range(1000, 9000));
				default: apply_setting($urandom_range(0, 1), $urandom_range(1, 4),
					4096, 4096, -4096, 4096);
			endcase
			if (p == 2)
				press_go = 1;
			send_random(100, p % 3 != 2);
			drain();
		end

		$display("Run covered %0d results, %0d with limiting, over 22 register settings.",
			result_count, limited_count);
		if (fail_count == 0)
			$display("SUCCESS");
		else
			$display("FAILURE");
		$finish;
	end

endmodule

### dq_current_two_stage_limiter.f
rtl/core/dql_pkg.sv
rtl/core/dql_isqrt.sv
rtl/core/dql_div.sv
rtl/core/dq_current_two_stage_limiter.sv
verif/dql_checker.sv
verif/tb_top.sv
